FILE: rtl/gcalf_pkg.sv
package gcalf_pkg;

    localparam int CORDIC_STAGES_DEFAULT = 16;
    localparam int ATAN_LEN = 24;

    localparam logic [21:0] ATAN_Q16 [ATAN_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379, 22'd117304, 22'd58666, 22'd29335,
        22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115,
        22'd57, 22'd29, 22'd14, 22'd7,
        22'd4, 22'd2, 22'd1, 22'd0
    };

    localparam int XY_W = 34;
    localparam int ZR_W = 25;
    localparam int ZV_W = 26;
    localparam int TRIG_W = 32;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [ZV_W-1:0] RIGHT_ANGLE_Q16 = 26'sd5898240;

    localparam int ISQRT_STEPS = 31;
    localparam int ISQ_W = 62;

    localparam logic [15:0] HALF_TURN = 16'd46080;
    localparam logic [15:0] FADE_START = 16'd17920;
    localparam logic [15:0] FADE_STOP = 16'd23040;
    localparam logic [15:0] BOOST_ONE = 16'd32768;
    localparam logic [16:0] DIV5_RECIP = 17'd52429;
    localparam int DIV5_SHIFT = 18;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REG_HOME_LATITUDE = 2'd0,
        REG_HOME_LONGITUDE = 2'd1,
        REG_BOOST_ENABLE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [ZR_W-1:0] z;
        logic neg;
    } angle_t;

    typedef struct packed {
        angle_t hlat;
        angle_t hlon;
        angle_t plat;
        angle_t plon;
    } q_entry_t;

    function automatic angle_t fold_angle(input logic signed [16:0] a);
        logic signed [17:0] w;
        angle_t r;
        w = {a[16], a};
        if (w >= 18'sd46080) begin
            w = w - 18'sd92160;
        end else if (w < -18'sd46080) begin
            w = w + 18'sd92160;
        end
        r.neg = 1'b0;
        if (w > 18'sd23040) begin
            w = w - 18'sd46080;
            r.neg = 1'b1;
        end else if (w < -18'sd23040) begin
            w = w + 18'sd46080;
            r.neg = 1'b1;
        end
        r.z = {w[16:0], 8'b0};
        return r;
    endfunction

endpackage

FILE: rtl/gcalf_front.sv
module gcalf_front (
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] point_latitude,
    input  logic signed [16:0] point_longitude,
    input  logic signed [15:0] home_latitude,
    input  logic signed [16:0] home_longitude,
    input  logic               q_full,
    output logic               push,
    output gcalf_pkg::q_entry_t push_data
);
    import gcalf_pkg::*;

    assign in_stall = q_full;
    assign push = in_valid && !q_full;

    always_comb
    begin
        push_data.hlat = fold_angle({home_latitude[15], home_latitude});
        push_data.hlon = fold_angle(home_longitude);
        push_data.plat = fold_angle({point_latitude[15], point_latitude});
        push_data.plon = fold_angle(point_longitude);
    end

endmodule

FILE: rtl/gcalf_queue.sv
module gcalf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gcalf_pkg::q_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output gcalf_pkg::q_entry_t head
);
    import gcalf_pkg::*;

    q_entry_t entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/gcalf_sincos.sv
module gcalf_sincos #(
    parameter int CORDIC_STAGES = gcalf_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [gcalf_pkg::ZR_W-1:0]        z_in,
    input  logic                                     neg_in,
    output logic signed [gcalf_pkg::TRIG_W-1:0]      sin_out,
    output logic signed [gcalf_pkg::TRIG_W-1:0]      cos_out
);
    import gcalf_pkg::*;

    logic signed [XY_W-1:0] x_reg [CORDIC_STAGES];
    logic signed [XY_W-1:0] y_reg [CORDIC_STAGES];
    logic signed [ZR_W-1:0] z_reg [CORDIC_STAGES];
    logic                   neg_reg [CORDIC_STAGES];
    logic signed [TRIG_W-1:0] sin_reg, cos_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [XY_W-1:0] xp, yp;
        logic signed [ZR_W-1:0] zp;
        logic                   np;
        logic signed [ZR_W-1:0] at;

        if (i == 0) begin : g_first
            assign xp = CORDIC_GAIN_Q30;
            assign yp = '0;
            assign zp = z_in;
            assign np = neg_in;
        end else begin : g_next
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
            assign np = neg_reg[i-1];
        end

        assign at = $signed(ZR_W'(ATAN_Q16[i]));

        always_ff @(posedge clk)
        begin
            if (en) begin
                if (!zp[ZR_W-1]) begin
                    x_reg[i] <= xp - (yp >>> i);
                    y_reg[i] <= yp + (xp >>> i);
                    z_reg[i] <= zp - at;
                end else begin
                    x_reg[i] <= xp + (yp >>> i);
                    y_reg[i] <= yp - (xp >>> i);
                    z_reg[i] <= zp + at;
                end
                neg_reg[i] <= np;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            if (neg_reg[CORDIC_STAGES-1]) begin
                sin_reg <= TRIG_W'(-y_reg[CORDIC_STAGES-1]);
                cos_reg <= TRIG_W'(-x_reg[CORDIC_STAGES-1]);
            end else begin
                sin_reg <= TRIG_W'(y_reg[CORDIC_STAGES-1]);
                cos_reg <= TRIG_W'(x_reg[CORDIC_STAGES-1]);
            end
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

FILE: rtl/gcalf_back.sv
module gcalf_back #(
    parameter int CORDIC_STAGES = gcalf_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  gcalf_pkg::q_entry_t head,
    output logic                pop,
    input  logic                boost_enable,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         angle_degrees,
    output logic [15:0]         light_boost
);
    import gcalf_pkg::*;

    localparam int LAT = 2 * CORDIC_STAGES + 40;

    logic adv;
    logic [LAT-1:0] vld_reg;

    logic signed [TRIG_W-1:0] hsla, hcla, hslo, hclo, psla, pcla, pslo, pclo;

    logic signed [63:0] p_hx, p_hy, p_px, p_py;
    logic signed [TRIG_W-1:0] hx_reg, hy_reg, hz_reg, px_reg, py_reg, pz_reg;
    logic signed [63:0] xx_reg, yy_reg, zz_reg;
    logic signed [63:0] dsum;
    logic signed [33:0] dot;
    logic signed [TRIG_W-1:0] d_reg, d4_reg;
    logic signed [63:0] dd;
    logic [60:0] v_reg;

    logic [60:0]         isq_v_reg [ISQRT_STEPS];
    logic [ISQ_W-1:0]    isq_r_reg [ISQRT_STEPS];
    logic signed [TRIG_W-1:0] isq_d_reg [ISQRT_STEPS];

    logic signed [XY_W-1:0] ax_reg [CORDIC_STAGES + 1];
    logic signed [XY_W-1:0] ay_reg [CORDIC_STAGES + 1];
    logic signed [ZV_W-1:0] az_reg [CORDIC_STAGES + 1];

    logic signed [ZV_W-1:0] zr;
    logic signed [17:0] rnd;
    logic [15:0] ang_reg, angb_reg;
    logic [12:0] t;
    logic [17:0] n;
    logic [34:0] prod;
    logic [34:0] prod_reg;
    logic [15:0] angle_reg, boost_reg;

    assign adv = !(vld_reg[LAT-1] && out_stall);
    assign pop = adv && head_valid;
    assign out_valid = vld_reg[LAT-1];
    assign angle_degrees = angle_reg;
    assign light_boost = boost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], head_valid};
        end
    end

    gcalf_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_hlat (
        .clk(clk), .en(adv), .z_in(head.hlat.z), .neg_in(head.hlat.neg),
        .sin_out(hsla), .cos_out(hcla)
    );
    gcalf_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_hlon (
        .clk(clk), .en(adv), .z_in(head.hlon.z), .neg_in(head.hlon.neg),
        .sin_out(hslo), .cos_out(hclo)
    );
    gcalf_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_plat (
        .clk(clk), .en(adv), .z_in(head.plat.z), .neg_in(head.plat.neg),
        .sin_out(psla), .cos_out(pcla)
    );
    gcalf_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_plon (
        .clk(clk), .en(adv), .z_in(head.plon.z), .neg_in(head.plon.neg),
        .sin_out(pslo), .cos_out(pclo)
    );

    assign p_hx = hclo * hcla;
    assign p_hy = hslo * hcla;
    assign p_px = pclo * pcla;
    assign p_py = pslo * pcla;

    always_ff @(posedge clk)
    begin
        if (adv) begin
            hx_reg <= p_hx[61:30];
            hy_reg <= p_hy[61:30];
            hz_reg <= hsla;
            px_reg <= p_px[61:30];
            py_reg <= p_py[61:30];
            pz_reg <= psla;
            xx_reg <= hx_reg * px_reg;
            yy_reg <= hy_reg * py_reg;
            zz_reg <= hz_reg * pz_reg;
        end
    end

    assign dsum = xx_reg + yy_reg + zz_reg;
    assign dot = dsum[63:30];
    assign dd = d_reg * d_reg;

    always_ff @(posedge clk)
    begin
        if (adv) begin
            if (dot > 34'sd1073741824) begin
                d_reg <= 32'sd1073741824;
            end else if (dot < -34'sd1073741824) begin
                d_reg <= -32'sd1073741824;
            end else begin
                d_reg <= dot[31:0];
            end
            v_reg <= 61'((64'sd1 <<< 60) - dd);
            d4_reg <= d_reg;
        end
    end

    for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_isqrt
        localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (60 - 2 * k);
        logic [60:0]      vp;
        logic [ISQ_W-1:0] rp;
        logic signed [TRIG_W-1:0] dp;
        logic [ISQ_W-1:0] trial;

        if (k == 0) begin : g_first
            assign vp = v_reg;
            assign rp = '0;
            assign dp = d4_reg;
        end else begin : g_next
            assign vp = isq_v_reg[k-1];
            assign rp = isq_r_reg[k-1];
            assign dp = isq_d_reg[k-1];
        end

        assign trial = rp + BIT;

        always_ff @(posedge clk)
        begin
            if (adv) begin
                if ({1'b0, vp} >= trial) begin
                    isq_v_reg[k] <= 61'({1'b0, vp} - trial);
                    isq_r_reg[k] <= (rp >> 1) + BIT;
                end else begin
                    isq_v_reg[k] <= vp;
                    isq_r_reg[k] <= rp >> 1;
                end
                isq_d_reg[k] <= dp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            if (isq_d_reg[ISQRT_STEPS-1][TRIG_W-1]) begin
                ax_reg[0] <= $signed({2'b00, isq_r_reg[ISQRT_STEPS-1][31:0]});
                ay_reg[0] <= -XY_W'(isq_d_reg[ISQRT_STEPS-1]);
                az_reg[0] <= RIGHT_ANGLE_Q16;
            end else begin
                ax_reg[0] <= XY_W'(isq_d_reg[ISQRT_STEPS-1]);
                ay_reg[0] <= $signed({2'b00, isq_r_reg[ISQRT_STEPS-1][31:0]});
                az_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_acos
        logic signed [ZV_W-1:0] at;

        assign at = $signed(ZV_W'(ATAN_Q16[i]));

        always_ff @(posedge clk)
        begin
            if (adv) begin
                if (!ay_reg[i][XY_W-1]) begin
                    ax_reg[i+1] <= ax_reg[i] + (ay_reg[i] >>> i);
                    ay_reg[i+1] <= ay_reg[i] - (ax_reg[i] >>> i);
                    az_reg[i+1] <= az_reg[i] + at;
                end else begin
                    ax_reg[i+1] <= ax_reg[i] - (ay_reg[i] >>> i);
                    ay_reg[i+1] <= ay_reg[i] + (ax_reg[i] >>> i);
                    az_reg[i+1] <= az_reg[i] - at;
                end
            end
        end
    end

    assign zr = az_reg[CORDIC_STAGES] + ZV_W'(128);
    assign rnd = zr[ZV_W-1:8];

    assign t = 13'(FADE_STOP - ang_reg);
    assign n = {t, 5'b0} + 18'd2;
    assign prod = n * DIV5_RECIP;

    always_ff @(posedge clk)
    begin
        if (adv) begin
            if (rnd[17]) begin
                ang_reg <= '0;
            end else if (rnd > $signed({2'b00, HALF_TURN})) begin
                ang_reg <= HALF_TURN;
            end else begin
                ang_reg <= rnd[15:0];
            end
            angb_reg <= ang_reg;
            prod_reg <= prod;
            angle_reg <= angb_reg;
            if (!boost_enable) begin
                boost_reg <= '0;
            end else if (angb_reg < FADE_START) begin
                boost_reg <= BOOST_ONE;
            end else if (angb_reg < FADE_STOP) begin
                boost_reg <= prod_reg[DIV5_SHIFT+15:DIV5_SHIFT];
            end else begin
                boost_reg <= '0;
            end
        end
    end

endmodule

FILE: rtl/great_circle_angle_light_fade.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  point_latitude, point_longitude
// output    out        out_valid/out_stall  angle_degrees, light_boost
// config    in         cfg_write            cfg_index, cfg_data
//
// One point is taken every cycle while the queue is not full; a result
// passes from its input transfer through the sine/cosine CORDIC pipeline, the
// 31 step square root pipeline and the arccosine CORDIC pipeline.
// Reset clears the queue, the valid line and sets the configuration defaults.
// An output stall while out_valid is high freezes the back pipeline; the
// four entry queue keeps taking input until it is full.
module great_circle_angle_light_fade #(
    parameter int CORDIC_STAGES = gcalf_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] point_latitude,
    input  logic signed [16:0] point_longitude,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        angle_degrees,
    output logic [15:0]        light_boost,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);
    import gcalf_pkg::*;

    logic signed [15:0] home_lat_reg;
    logic signed [16:0] home_lon_reg;
    logic               boost_en_reg;

    logic     push, q_full, pop, head_valid;
    q_entry_t push_data, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            home_lat_reg <= '0;
            home_lon_reg <= '0;
            boost_en_reg <= 1'b1;
        end else if (cfg_write) begin
            case (cfg_index_t'(cfg_index))
                REG_HOME_LATITUDE:  home_lat_reg <= cfg_data[15:0];
                REG_HOME_LONGITUDE: home_lon_reg <= cfg_data;
                REG_BOOST_ENABLE:   boost_en_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    gcalf_front u_front (
        .in_valid(in_valid),
        .in_stall(in_stall),
        .point_latitude(point_latitude),
        .point_longitude(point_longitude),
        .home_latitude(home_lat_reg),
        .home_longitude(home_lon_reg),
        .q_full(q_full),
        .push(push),
        .push_data(push_data)
    );

    gcalf_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data(push_data),
        .full(q_full),
        .pop(pop),
        .head_valid(head_valid),
        .head(head)
    );

    gcalf_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head_valid(head_valid),
        .head(head),
        .pop(pop),
        .boost_enable(boost_en_reg),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .angle_degrees(angle_degrees),
        .light_boost(light_boost)
    );

endmodule

FILE: rtl/gcalf_checker.sv
module gcalf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] angle_degrees,
    input logic [15:0] light_boost
);
    import gcalf_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Output valid dropped during a stalled transfer.");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(angle_degrees) && $stable(light_boost))
        else $error("Output payload changed during a stalled transfer.");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle_degrees <= HALF_TURN)
        else $error("Angle exceeds a half turn.");

    a_boost_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> light_boost <= BOOST_ONE)
        else $error("Boost exceeds one.");

    a_boost_far: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && angle_degrees >= FADE_STOP |-> light_boost == '0)
        else $error("Boost is nonzero beyond the fade range.");

endmodule

bind great_circle_angle_light_fade gcalf_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .angle_degrees(angle_degrees),
    .light_boost(light_boost)
);
